FILE: hdl/lca_pkg.sv
// Shared types and constants for the two-channel LED current AGC.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lca_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CUR_W      = 10;
  localparam int unsigned RUN_W      = 16;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CUR_W-1:0] INIT_CURRENT = CUR_W'(512);

  // Reset values of the configuration registers.
  localparam logic [CUR_W-1:0] STEP_RESET = CUR_W'(1);
  localparam logic [CUR_W-1:0] MAX_RESET  = CUR_W'(1023);

  // Channel select codes.
  localparam logic CH_INFRARED = 1'b0;
  localparam logic CH_RED      = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_IR   = 3'd0,
    REG_TARGET_RED  = 3'd1,
    REG_TOL_NARROW  = 3'd2,
    REG_TOL_WIDE    = 3'd3,
    REG_PERSIST     = 3'd4,
    REG_STEP        = 3'd5,
    REG_MAX_IR      = 3'd6,
    REG_MAX_RED     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] target_infrared;
    logic [SAMPLE_W-1:0] target_red;
    logic [SAMPLE_W-1:0] tolerance_narrow;
    logic [SAMPLE_W-1:0] tolerance_wide;
    logic [RUN_W-1:0]    persist_limit;
    logic [CUR_W-1:0]    current_step;
    logic [CUR_W-1:0]    max_infrared;
    logic [CUR_W-1:0]    max_red;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/lca_if.sv
// Handshake channels of the LED current AGC: sample input, result output,
// configuration writes. Depends on lca_pkg.
`default_nettype none

interface lca_in_if import lca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                channel;

  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

interface lca_out_if import lca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CUR_W-1:0] drive_current;
  logic             changed;
  logic             settled;

  modport source (output valid, drive_current, changed, settled, input ready);
  modport sink   (input valid, drive_current, changed, settled, output ready);
endinterface

interface lca_cfg_if import lca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lca_cfg.sv
// Configuration register file of the LED current AGC.
// Depends on lca_pkg and lca_cfg_if.
`default_nettype none

module lca_cfg import lca_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lca_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_infrared  <= '0;
      cfg_q.target_red       <= '0;
      cfg_q.tolerance_narrow <= '0;
      cfg_q.tolerance_wide   <= '0;
      cfg_q.persist_limit    <= '0;
      cfg_q.current_step     <= STEP_RESET;
      cfg_q.max_infrared     <= MAX_RESET;
      cfg_q.max_red          <= MAX_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_TARGET_IR:  cfg_q.target_infrared  <= cfg_i.data[SAMPLE_W-1:0];
        REG_TARGET_RED: cfg_q.target_red       <= cfg_i.data[SAMPLE_W-1:0];
        REG_TOL_NARROW: cfg_q.tolerance_narrow <= cfg_i.data[SAMPLE_W-1:0];
        REG_TOL_WIDE:   cfg_q.tolerance_wide   <= cfg_i.data[SAMPLE_W-1:0];
        REG_PERSIST:    cfg_q.persist_limit    <= cfg_i.data[RUN_W-1:0];
        REG_STEP:       cfg_q.current_step     <= cfg_i.data[CUR_W-1:0];
        REG_MAX_IR:     cfg_q.max_infrared     <= cfg_i.data[CUR_W-1:0];
        REG_MAX_RED:    cfg_q.max_red          <= cfg_i.data[CUR_W-1:0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lca_step.sv
// Per-sample decision logic: band compares, current step and run counter.
// Depends on lca_pkg.
`default_nettype none

module lca_step import lca_pkg::*; (
  input  cfg_t                cfg_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                channel_i,
  input  wire logic [CUR_W-1:0]    cur_i,
  input  wire logic [RUN_W-1:0]    runs_i,
  output logic [CUR_W-1:0]    cur_o,
  output logic [RUN_W-1:0]    runs_o,
  output logic                changed_o,
  output logic                settled_o
);

  function automatic logic [SAMPLE_W-1:0] sat_sub(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  logic [SAMPLE_W-1:0] target;
  logic [SAMPLE_W-1:0] tol;
  logic [CUR_W-1:0]    maxc;
  logic [SAMPLE_W:0]   hi_tol, hi_wide, hi_narrow;
  logic [SAMPLE_W-1:0] lo_tol, lo_wide, lo_narrow;
  logic [CUR_W:0]      cur_sum;
  logic                above, below;

  always_comb begin
    target    = (channel_i == CH_RED) ? cfg_i.target_red : cfg_i.target_infrared;
    maxc      = (channel_i == CH_RED) ? cfg_i.max_red : cfg_i.max_infrared;
    tol       = (runs_i > cfg_i.persist_limit) ? cfg_i.tolerance_wide
                                               : cfg_i.tolerance_narrow;
    hi_tol    = {1'b0, target} + {1'b0, tol};
    hi_wide   = {1'b0, target} + {1'b0, cfg_i.tolerance_wide};
    hi_narrow = {1'b0, target} + {1'b0, cfg_i.tolerance_narrow};
    lo_tol    = sat_sub(target, tol);
    lo_wide   = sat_sub(target, cfg_i.tolerance_wide);
    lo_narrow = sat_sub(target, cfg_i.tolerance_narrow);
    cur_sum   = {1'b0, cur_i} + {1'b0, cfg_i.current_step};
    above     = {1'b0, sample_i} > hi_tol;
    below     = sample_i < lo_tol;

    cur_o     = cur_i;
    runs_o    = runs_i;
    changed_o = 1'b0;

    priority if (above) begin
      if ({1'b0, sample_i} > hi_wide) runs_o = '0;
      if (cur_i > cfg_i.current_step) begin
        cur_o     = cur_i - cfg_i.current_step;
        changed_o = 1'b1;
      end
    end else if (below) begin
      if (sample_i < lo_wide) runs_o = '0;
      if (cur_sum < {1'b0, maxc}) begin
        cur_o     = cur_sum[CUR_W-1:0];
        changed_o = 1'b1;
      end
    end else begin
      // Count only samples strictly inside the narrow window; hold at full.
      if (sample_i > lo_narrow && {1'b0, sample_i} < hi_narrow && runs_i != '1) begin
        runs_o = runs_i + RUN_W'(1);
      end
    end

    settled_o = runs_o > cfg_i.persist_limit;
  end

endmodule

`default_nettype wire

FILE: hdl/led_current_agc_two_channel_top.sv
// Top level of the two-channel LED drive-current AGC.
// Depends on lca_pkg, lca_if, lca_cfg and lca_step.
//
//   channel  | dir | fields                               | handshake
//   ---------+-----+--------------------------------------+-------------
//   in_i     | in  | sample[23:0], channel                | valid/ready
//   out_o    | out | drive_current[9:0], changed, settled | valid/ready
//   cfg_i    | in  | index[2:0], data[23:0]               | valid/ready
//
// One beat per cycle while the output is not stalled: a sample is registered
// at the input, then the decision logic and the per-channel state update run
// in the next cycle, with the result landing in the output register.
// The state is read and written in the same stage, so consecutive samples of
// one channel see each other's updates without bubbles.
// Reset clears both pipeline valids, loads INIT_CURRENT into both drive
// currents and zeroes both run counters. A stalled output holds its beat;
// the input stage keeps accepting until it too is full.
`default_nettype none

module led_current_agc_two_channel_top import lca_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lca_in_if.sink    in_i,
  lca_out_if.source out_o,
  lca_cfg_if.sink   cfg_i
);

  cfg_t cfg;

  // Input stage.
  logic                in_vld_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                chan_q;

  // Output stage.
  logic                out_vld_q;
  logic [CUR_W-1:0]    cur_out_q;
  logic                changed_q;
  logic                settled_q;

  // Per-channel state, indexed by channel select.
  logic [CUR_W-1:0]    led_drive_q [2];
  logic [RUN_W-1:0]    runs_q      [2];

  logic                advance;
  logic                in_acc;
  logic [CUR_W-1:0]    cur_d;
  logic [RUN_W-1:0]    runs_d;
  logic                changed_d;
  logic                settled_d;

  lca_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lca_step u_step (
    .cfg_i     (cfg),
    .sample_i  (sample_q),
    .channel_i (chan_q),
    .cur_i     (led_drive_q[chan_q]),
    .runs_i    (runs_q[chan_q]),
    .cur_o     (cur_d),
    .runs_o    (runs_d),
    .changed_o (changed_d),
    .settled_o (settled_d)
  );

  // Move the held sample on when the output register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.sample;
      chan_q   <= in_i.channel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cur_out_q <= cur_d;
      changed_q <= changed_d;
      settled_q <= settled_d;
    end
  end

  // Commit the channel state together with its result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        led_drive_q[i] <= INIT_CURRENT;
        runs_q[i]      <= '0;
      end
    end else if (advance) begin
      led_drive_q[chan_q] <= cur_d;
      runs_q[chan_q]      <= runs_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.drive_current = cur_out_q;
  assign out_o.changed       = changed_q;
  assign out_o.settled       = settled_q;

endmodule

`default_nettype wire

FILE: hdl/lca_checker.sv
// Port-level checks for the LED current AGC top level, bound to it below.
// Depends on led_current_agc_two_channel_top and its interfaces.
`default_nettype none

module lca_checker import lca_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CUR_W-1:0] out_current,
  input wire logic             out_changed,
  input wire logic             out_settled
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("output valid during reset");

  // A fresh result follows an accepted sample: it goes first into the input
  // register, and from there into the output register.
  a_rise_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding sample");

  // With the output register empty the input side never stalls.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_current)
      && $stable(out_changed) && $stable(out_settled))
    else $error("stalled result changed");

endmodule

bind led_current_agc_two_channel_top lca_checker u_lca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_current (out_o.drive_current),
  .out_changed (out_o.changed),
  .out_settled (out_o.settled)
);

`default_nettype wire

FILE: tb/led_current_agc_two_channel_top_test.sv
// Self-checking bench for led_current_agc_two_channel_top: a short table of directed
// samples, then random samples under changing settings.
// Depends on lca_pkg, the lca_*_if interfaces and the block's RTL.

module led_current_agc_two_channel_top_test;
  import lca_pkg::*;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [CUR_W-1:0] drive_current;
    logic             changed;
    logic             settled;
  } agc_result_t;

  // A row of the directed table: a register write, or a sample with an optional
  // result that is typed in by hand.
  typedef struct {
    bit                    is_reg;
    reg_idx_e              idx;
    logic [SAMPLE_W-1:0]   value;
    logic                  ch;
    bit                    typed;
    agc_result_t           want;
  } drill_row_t;

  logic clk_i;
  logic rst_ni;

  lca_in_if  sample_bus ();
  lca_out_if result_bus ();
  lca_cfg_if reg_bus ();

  led_current_agc_two_channel_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_bus),
    .out_o  (result_bus),
    .cfg_i  (reg_bus)
  );

  // Per-cycle idle chances of the sample sender and the result receiver, in percent.
  int tx_idle_pct = 17;
  int rx_idle_pct = 58;
  int mismatches  = 0;

  // Predictor state: settings, drive current and in-window run count per channel.
  cfg_t             agc_settings;
  logic [CUR_W-1:0] drive_now   [2];
  logic [RUN_W-1:0] window_runs [2];

  // Results still owed by the block, oldest first.
  agc_result_t levels_due [$];

  drill_row_t drills [32];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Print one line per mismatch, but keep the log short if the block is badly off.
  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t: %s", $time, what);
  endtask

  function automatic logic [SAMPLE_W:0] floor_sub(input logic [SAMPLE_W:0] a,
                                                  input logic [SAMPLE_W:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Work out the result of one accepted sample and advance the channel's state.
  // Band edges are formed one bit wider than a sample so target plus tolerance
  // never wraps; target minus tolerance floors at zero.
  function automatic agc_result_t agc_track(input logic [SAMPLE_W-1:0] s, input logic ch);
    logic [SAMPLE_W:0] tgt;
    logic [SAMPLE_W:0] narrow;
    logic [SAMPLE_W:0] wide;
    logic [SAMPLE_W:0] tol;
    logic [CUR_W:0]    cur;
    logic [CUR_W-1:0]  top;
    logic [RUN_W-1:0]  runs;
    agc_result_t       r;
    tgt    = (ch == CH_RED) ? {1'b0, agc_settings.target_red}
                            : {1'b0, agc_settings.target_infrared};
    top    = (ch == CH_RED) ? agc_settings.max_red : agc_settings.max_infrared;
    narrow = {1'b0, agc_settings.tolerance_narrow};
    wide   = {1'b0, agc_settings.tolerance_wide};
    cur    = {1'b0, drive_now[ch]};
    runs   = window_runs[ch];
    tol    = (runs > agc_settings.persist_limit) ? wide : narrow;
    r      = '0;
    if (s > tgt + tol) begin
      if (s > tgt + wide) runs = '0;
      if (cur > agc_settings.current_step) begin
        cur = cur - agc_settings.current_step;
        r.changed = 1'b1;
      end
    end else if (s < floor_sub(tgt, tol)) begin
      if (s < floor_sub(tgt, wide)) runs = '0;
      if (cur + agc_settings.current_step < top) begin
        cur = cur + agc_settings.current_step;
        r.changed = 1'b1;
      end
    end else if (s > floor_sub(tgt, narrow) && s < tgt + narrow && runs != '1) begin
      runs = runs + 1'b1;
    end
    drive_now[ch]   = cur[CUR_W-1:0];
    window_runs[ch] = runs;
    r.drive_current = cur[CUR_W-1:0];
    r.settled       = (runs > agc_settings.persist_limit);
    return r;
  endfunction

  function automatic drill_row_t drill_reg(input reg_idx_e idx, input logic [SAMPLE_W-1:0] v);
    drill_row_t d;
    d = '{1'b1, idx, v, CH_INFRARED, 1'b0, '0};
    return d;
  endfunction

  function automatic drill_row_t drill_in(input logic [SAMPLE_W-1:0] s, input logic ch);
    drill_row_t d;
    d = '{1'b0, REG_TARGET_IR, s, ch, 1'b0, '0};
    return d;
  endfunction

  function automatic drill_row_t drill_known(input logic [SAMPLE_W-1:0] s, input logic ch,
                                             input int cur, input logic chg, input logic stl);
    drill_row_t d;
    d = '{1'b0, REG_TARGET_IR, s, ch, 1'b1, {CUR_W'(cur), chg, stl}};
    return d;
  endfunction

  // Write one register and mirror it in the predictor, masked to the register's width.
  // Leave valid high: the caller drops it once the whole group is written.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= d;
    do @(posedge clk_i); while (!reg_bus.ready);
    case (idx)
      REG_TARGET_IR:  agc_settings.target_infrared  = d;
      REG_TARGET_RED: agc_settings.target_red       = d;
      REG_TOL_NARROW: agc_settings.tolerance_narrow = d;
      REG_TOL_WIDE:   agc_settings.tolerance_wide   = d;
      REG_PERSIST:    agc_settings.persist_limit    = d[RUN_W-1:0];
      REG_STEP:       agc_settings.current_step     = d[CUR_W-1:0];
      REG_MAX_IR:     agc_settings.max_infrared     = d[CUR_W-1:0];
      REG_MAX_RED:    agc_settings.max_red          = d[CUR_W-1:0];
      default: ;
    endcase
  endtask

  // Write all eight registers; half the time fill the unused upper data bits with junk.
  task automatic program_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(1) == 1) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_TARGET_IR,  s.target_infrared);
    write_reg(REG_TARGET_RED, s.target_red);
    write_reg(REG_TOL_NARROW, s.tolerance_narrow);
    write_reg(REG_TOL_WIDE,   s.tolerance_wide);
    write_reg(REG_PERSIST,    {junk[CFG_DATA_W-1:RUN_W], s.persist_limit});
    write_reg(REG_STEP,       {junk[CFG_DATA_W-1:CUR_W], s.current_step});
    write_reg(REG_MAX_IR,     {junk[CFG_DATA_W-1:CUR_W], s.max_infrared});
    write_reg(REG_MAX_RED,    {junk[CFG_DATA_W-1:CUR_W], s.max_red});
    reg_bus.valid <= 1'b0;
  endtask

  // Hold the sender until every owed result is back, then let the pipeline go quiet.
  task automatic settle_pipe();
    sample_bus.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one sample beat, idling first at the sender's rate. Valid stays high on
  // return so back-to-back beats never drop it within one step.
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic ch,
                             input bit typed = 1'b0, input agc_result_t want = '0);
    agc_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid   <= 1'b1;
    sample_bus.sample  <= s;
    sample_bus.channel <= ch;
    do @(posedge clk_i); while (!sample_bus.ready);
    predicted = agc_track(s, ch);
    levels_due.push_back(typed ? want : predicted);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_target();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(3000));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random settings: mostly narrow bands and short persistence so channels settle,
  // with the register extremes mixed in.
  function automatic cfg_t pick_settings();
    cfg_t   s;
    longint w;
    s.target_infrared = pick_target();
    s.target_red      = pick_target();
    case ($urandom_range(9))
      0:       s.tolerance_narrow = '0;
      1:       s.tolerance_narrow = '1;
      default: s.tolerance_narrow = SAMPLE_W'($urandom_range(2000));
    endcase
    case ($urandom_range(9))
      0:       s.tolerance_wide = '0;
      1:       s.tolerance_wide = '1;
      2:       s.tolerance_wide = SAMPLE_W'($urandom_range(s.tolerance_narrow));
      default: begin
        w = longint'(s.tolerance_narrow) + longint'($urandom_range(4000));
        s.tolerance_wide = (w > longint'(24'hFFFFFF)) ? '1 : w[SAMPLE_W-1:0];
      end
    endcase
    case ($urandom_range(9))
      0:       s.persist_limit = '1;
      1:       s.persist_limit = 16'hFFFE;
      default: s.persist_limit = RUN_W'($urandom_range(8));
    endcase
    case ($urandom_range(9))
      0:       s.current_step = '0;
      1:       s.current_step = 10'd1;
      2:       s.current_step = '1;
      default: s.current_step = CUR_W'($urandom_range(150));
    endcase
    case ($urandom_range(9))
      0:       s.max_infrared = '0;
      1:       s.max_infrared = '1;
      default: s.max_infrared = CUR_W'($urandom_range(1023));
    endcase
    case ($urandom_range(9))
      0:       s.max_red = '0;
      1:       s.max_red = '1;
      default: s.max_red = CUR_W'($urandom_range(1023));
    endcase
    return s;
  endfunction

  // Random sample for a channel: mostly inside the narrow band so the run counter
  // climbs, some around the wide band, some at the band edges, some pure noise.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic ch);
    longint t;
    longint n;
    longint w;
    longint v;
    t = (ch == CH_RED) ? longint'(agc_settings.target_red)
                       : longint'(agc_settings.target_infrared);
    n = longint'(agc_settings.tolerance_narrow);
    w = longint'(agc_settings.tolerance_wide);
    case ($urandom_range(9))
      0: v = longint'($urandom_range(24'hFFFFFF));
      1: begin
        case ($urandom_range(7))
          0:       v = 0;
          1:       v = longint'(24'hFFFFFF);
          2:       v = t - n;
          3:       v = t + n;
          4:       v = t - w;
          5:       v = t + w;
          6:       v = t - w - 1;
          default: v = t + w + 1;
        endcase
      end
      2, 3, 4, 5, 6: v = t - n + longint'($urandom_range(32'(2 * n)));
      default:       v = t - w - 2 + longint'($urandom_range(32'(2 * w + 4)));
    endcase
    if (v < 0) v = 0;
    if (v > longint'(24'hFFFFFF)) v = longint'(24'hFFFFFF);
    return v[SAMPLE_W-1:0];
  endfunction

  // Compare one accepted result beat against the oldest owed result, field by field.
  task automatic check_result();
    agc_result_t want;
    if (levels_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result: current %0d changed %0b settled %0b",
                              result_bus.drive_current, result_bus.changed,
                              result_bus.settled));
      return;
    end
    want = levels_due.pop_front();
    if (result_bus.drive_current !== want.drive_current)
      flag_mismatch($sformatf("drive_current %0d, want %0d",
                              result_bus.drive_current, want.drive_current));
    if (result_bus.changed !== want.changed)
      flag_mismatch($sformatf("changed %0b, want %0b", result_bus.changed, want.changed));
    if (result_bus.settled !== want.settled)
      flag_mismatch($sformatf("settled %0b, want %0b", result_bus.settled, want.settled));
  endtask

  // Result side: check the beat taken at this edge, then draw ready for the next cycle.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid && result_bus.ready) check_result();
      result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    cfg_t plan;
    logic ch;
    bit   streaming;
    bit   reg_open;

    rst_ni             <= 1'b0;
    sample_bus.valid   <= 1'b0;
    sample_bus.sample  <= '0;
    sample_bus.channel <= CH_INFRARED;
    reg_bus.valid      <= 1'b0;
    reg_bus.index      <= REG_TARGET_IR;
    reg_bus.data       <= '0;

    // Mirror the reset state: zero targets, tolerances and limit, step of one,
    // full-scale maxima, both channels at the initial current with no runs.
    agc_settings              = '0;
    agc_settings.current_step = STEP_RESET;
    agc_settings.max_infrared = MAX_RESET;
    agc_settings.max_red      = MAX_RESET;
    drive_now[0]   = INIT_CURRENT;
    drive_now[1]   = INIT_CURRENT;
    window_runs[0] = '0;
    window_runs[1] = '0;

    // Directed table. Only the first two rows, taken straight after reset, carry a
    // hand-typed result; the rest go through the predictor.
    drills = '{
      drill_known(24'h000000, CH_INFRARED, 512, 1'b0, 1'b0), // at target, nothing moves
      drill_known(24'hFFFFFF, CH_RED,      511, 1'b1, 1'b0), // full scale lowers by one
      drill_reg(REG_TARGET_IR,  24'd1000),
      drill_reg(REG_TARGET_RED, 24'hFFFFF0),
      drill_reg(REG_TOL_NARROW, 24'd10),
      drill_reg(REG_TOL_WIDE,   24'd100),
      drill_reg(REG_PERSIST,    24'd2),
      drill_reg(REG_STEP,       24'd200),
      drill_reg(REG_MAX_IR,     24'd1023),
      drill_reg(REG_MAX_RED,    24'd600),
      drill_in(24'd1000, CH_INFRARED),     // in window, count one
      drill_in(24'd991,  CH_INFRARED),     // just above the lower narrow edge
      drill_in(24'd1009, CH_INFRARED),     // third run: channel settles
      drill_in(24'd1050, CH_INFRARED),     // outside narrow, inside wide: hold
      drill_in(24'd1101, CH_INFRARED),     // beyond wide: clear and lower
      drill_in(24'd0,    CH_INFRARED),     // far below: clear and raise
      drill_in(24'd0,    CH_RED),          // current plus step past max blocks the raise
      drill_in(24'hFFFFF0, CH_RED),        // at target near full scale
      drill_in(24'hFFFFFF, CH_RED),        // upper edge must not wrap: run kept
      drill_in(24'hFFFFF5, CH_RED),
      drill_reg(REG_TARGET_IR,  24'd5),
      drill_in(24'd0,    CH_INFRARED),     // lower edge floors at zero, no raise
      drill_in(24'd1,    CH_INFRARED),
      drill_in(24'hFFFFFF, CH_INFRARED),
      drill_in(24'hFFFFFF, CH_INFRARED),
      drill_in(24'hFFFFFF, CH_INFRARED),   // current at or below step: floor holds
      drill_reg(REG_STEP,       24'd0),
      drill_in(24'hFFFFFF, CH_INFRARED),   // zero step still reports a change
      drill_in(24'd0,    CH_INFRARED),
      drill_reg(REG_STEP,       24'd1023),
      drill_in(24'd0,    CH_RED),
      drill_in(24'hFFFFFF, CH_RED)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table. Drain before any register write that follows samples, and
    // drop the write valid before the first sample after a group of writes.
    streaming = 1'b0;
    reg_open  = 1'b0;
    foreach (drills[i]) begin
      if (drills[i].is_reg) begin
        if (streaming) begin
          settle_pipe();
          streaming = 1'b0;
        end
        write_reg(drills[i].idx, drills[i].value);
        reg_open = 1'b1;
      end else begin
        if (reg_open) begin
          reg_bus.valid <= 1'b0;
          reg_open = 1'b0;
        end
        push_sample(drills[i].value, drills[i].ch, drills[i].typed, drills[i].want);
        streaming = 1'b1;
      end
    end

    // Random phases: sender lightly idle and receiver mostly stalled, then the
    // reverse, then both flat out. Each block runs under fresh settings; the very
    // first two blocks use all-ones and all-zero registers.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        settle_pipe();
        if (ph == 0 && blk == 0) plan = '1;
        else if (ph == 0 && blk == 1) plan = '0;
        else plan = pick_settings();
        program_settings(plan);
        for (int k = 0; k < 97; k++) begin
          // Now and then hold the sender until the block has emptied.
          if ($urandom_range(49) == 0) settle_pipe();
          ch = 1'($urandom_range(1));
          push_sample(pick_sample(ch), ch);
        end
      end
    end

    settle_pipe();
    if (mismatches == 0) begin
      $display("led_current_agc_two_channel_top: match");
    end else begin
      $display("led_current_agc_two_channel_top: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake: end the run well past the slowest correct finish.
  initial begin
    #10_000_000;
    $display("led_current_agc_two_channel_top: mismatch");
    $finish;
  end

endmodule
